>>> rtl/keyword_token_lexer_unit_defines.svh
// Assertion macros shared by the lexer RTL.
`ifndef KEYWORD_TOKEN_LEXER_UNIT_DEFINES_SVH
`define KEYWORD_TOKEN_LEXER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define KTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property during reset too.
`define KTL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> rtl/ktl_pkg.sv
// Package for the keyword token lexer: types, codes and keyword table.
package ktl_pkg;

    localparam int MaxTokenLen  = 255;
    localparam int KeywordCount = 25;
    localparam int KwMaxLen     = 12;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_BANG    = 3'd4,
        MODE_COMMENT = 3'd5,
        MODE_HALTED  = 3'd6
    } scan_mode_t;

    localparam logic [5:0] KIND_IDENT    = 6'd0;
    localparam logic [5:0] KIND_INT      = 6'd1;
    localparam logic [5:0] KIND_FLOAT    = 6'd2;
    localparam logic [5:0] KIND_STRING   = 6'd3;
    localparam logic [5:0] KIND_UNKNOWN  = 6'd4;
    localparam logic [5:0] KIND_KEYWORD0 = 6'd5;
    localparam logic [5:0] KIND_DELIM0   = 6'd30;
    localparam logic [5:0] KIND_END      = 6'd38;
    localparam logic [5:0] KIND_ERROR    = 6'd39;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] start_offset;
        logic [7:0]  token_length;
        logic [31:0] line_number;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_slot_t;

    typedef logic [KeywordCount-1:0] kw_mask_t;

    function automatic logic [7:0] kw_char(input int k, input int i);
        string s;
        case (k)
            0: s = "basla";        1: s = "bitir";       2: s = "eger";
            3: s = "yoksa";        4: s = "yap";         5: s = "cik";
            6: s = "tekrarla";     7: s = "degiskenler"; 8: s = "tersi";
            9: s = "esitle";       10: s = "cikar";      11: s = "carp";
            12: s = "bol";         13: s = "topla";      14: s = "esitse";
            15: s = "kucukse";     16: s = "buyukse";    17: s = "buyukesitse";
            18: s = "kucukesitse"; 19: s = "sayi";       20: s = "ondalik";
            21: s = "karakter";    22: s = "ikili";      23: s = "dogru";
            default: s = "yanlis";
        endcase
        kw_char = (i < s.len()) ? s[i] : 8'h00;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0, 1, 3, 8, 10, 13, 22, 23: kw_len = 4'd5;
            2, 11, 19:                  kw_len = 4'd4;
            4, 5, 12:                   kw_len = 4'd3;
            6, 21:                      kw_len = 4'd8;
            7, 17, 18:                  kw_len = 4'd11;
            9, 14, 24:                  kw_len = 4'd6;
            default:                    kw_len = 4'd7;
        endcase
    endfunction

endpackage

>>> rtl/ktl_kw_match.sv
// Keyword candidate mask update and final keyword decode.
module ktl_kw_match #(
    parameter int LenW = 8
) (
    input  ktl_pkg::kw_mask_t   mask_in,
    input  logic [LenW-1:0]     idx,
    input  logic [7:0]          char_code,
    input  logic [LenW-1:0]     close_len,
    output ktl_pkg::kw_mask_t   mask_out,
    output logic [5:0]          ident_kind
);
    import ktl_pkg::*;

    logic [7:0] lc;

    always_comb begin
        lc = (char_code inside {[8'h41:8'h5A]}) ? char_code + 8'd32 : char_code;
        for (int k = 0; k < KeywordCount; k++) begin
            mask_out[k] = 1'b0;
            for (int i = 0; i < KwMaxLen; i++) begin
                if (idx == LenW'(i) && i < int'(kw_len(k)) && kw_char(k, i) == lc)
                    mask_out[k] = mask_in[k];
            end
        end
        ident_kind = KIND_IDENT;
        for (int k = 0; k < KeywordCount; k++) begin
            if (mask_in[k] && close_len == LenW'(kw_len(k)))
                ident_kind = KIND_KEYWORD0 + 6'(k);
        end
    end

endmodule

>>> rtl/ktl_out_queue.sv
// Four-entry result queue between the scanner and the result channel.
module ktl_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ktl_pkg::res_slot_t  push_a,
    input  ktl_pkg::res_slot_t  push_b,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output ktl_pkg::out_item_t  m_item
);
    import ktl_pkg::*;

    out_item_t  ent_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       pop;
    logic [1:0] npush;

    assign m_valid  = cnt_reg != 3'd0;
    assign m_item   = ent_reg[rd_reg];
    assign pop      = m_valid && m_ready;
    assign can_push = cnt_reg <= 3'd2;
    assign npush    = push ? 2'(push_a.valid) + 2'(push_b.valid) : 2'd0;
    assign cnt_next = cnt_reg + 3'(npush) - 3'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 2'd0;
            wr_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_reg + npush;
            if (pop) rd_reg <= rd_reg + 2'd1;
        end
        if (push && push_a.valid) begin
            ent_reg[wr_reg] <= push_a.item;
            if (push_b.valid) ent_reg[wr_reg + 2'd1] <= push_b.item;
        end else if (push && push_b.valid) begin
            ent_reg[wr_reg] <= push_b.item;
        end
    end

    `include "keyword_token_lexer_unit_defines.svh"
    `KTL_ASSERT(a_cnt_bound, cnt_reg <= 3'd4, "queue overflow")
    `KTL_ASSERT(a_no_push_full, push |-> can_push, "push while full")
    `KTL_ASSERT(a_cnt_track, 1 |=> cnt_reg == $past(cnt_next), "count slip")

endmodule

>>> rtl/keyword_token_lexer_unit.sv
// Keyword token lexer: one character per cycle, up to two tokens per request.
//
// Input channel s_: one request carries a source byte or an end marker. Result
// channel m_: token records (kind, start offset, length, line, last flag).
// Each accepted request updates the scan state in the same cycle; its
// results (zero, one or two) enter a four-entry result queue, which presents
// them in order on m_. Throughput is one request per cycle while
// results drain as fast as they are made. The queue takes the two results of
// a request only while it holds at most two, so s_ready falls whenever more
// than two results wait: when the receiver stalls, or during a run of
// two-result requests, since results leave one per cycle.
// Reset (aresetn low, synchronous) empties the queue, sets line 1, position
// 0 and idle scan mode. After a single bang the block halts and answers every
// request with an error result until reset.
module keyword_token_lexer_unit #(
    parameter int MAX_TOKEN_LEN = ktl_pkg::MaxTokenLen
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ktl_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ktl_pkg::out_item_t  m_data
);
    import ktl_pkg::*;

    localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);

    scan_mode_t       mode_reg, mode_next;
    logic [31:0]      line_reg, line_next, pos_reg, start_reg, start_next;
    logic [LenW-1:0]  len_reg, len_next, len_sat;
    logic [1:0]       dots_reg, dots_next;
    kw_mask_t         mask_reg, mask_next, mask_upd;
    logic [5:0]       ident_kind;
    logic             acc;
    res_slot_t        ra, rb;
    logic [7:0]       c;
    logic             is_al, is_dg, is_pr, is_pu, id_cont;
    logic [5:0]       num_kind, punct_kind;
    logic [LenW-1:0]  idx;

    assign acc = s_valid && s_ready;
    assign c   = s_data.char_code;
    assign is_al = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign is_dg = (c inside {[8'h30:8'h39]});
    assign is_pr = (c inside {[8'h20:8'h7E]});
    assign is_pu = is_pr && c != 8'h20 && !is_al && !is_dg;
    assign id_cont = is_al || is_dg || c == 8'h5F;
    assign len_sat = (len_reg < LenW'(MAX_TOKEN_LEN)) ? len_reg + 1'b1 : len_reg;
    assign num_kind = dots_reg == 2'd0 ? KIND_INT : (dots_reg == 2'd1 ? KIND_FLOAT : KIND_UNKNOWN);
    assign idx = (mode_reg == MODE_IDENT) ? len_reg : '0;

    ktl_kw_match #(.LenW(LenW)) u_kw (
        .mask_in(mode_reg == MODE_IDENT ? mask_reg : '1),
        .idx(idx), .char_code(c), .close_len(len_reg),
        .mask_out(mask_upd), .ident_kind(ident_kind)
    );

    function automatic out_item_t mk(input logic [5:0] k, input logic [31:0] s,
                                     input logic [LenW-1:0] l, input logic [31:0] ln);
        out_item_t r;
        r.token_kind   = k;
        r.start_offset = s;
        r.token_length = (l > LenW'(255)) ? 8'd255 : 8'(l);
        r.line_number  = ln;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    always_comb begin
        punct_kind = KIND_UNKNOWN;
        case (c)
            8'h3B: punct_kind = KIND_DELIM0;
            8'h3A: punct_kind = KIND_DELIM0 + 6'd1;
            8'h28: punct_kind = KIND_DELIM0 + 6'd2;
            8'h29: punct_kind = KIND_DELIM0 + 6'd3;
            8'h5B: punct_kind = KIND_DELIM0 + 6'd4;
            8'h5D: punct_kind = KIND_DELIM0 + 6'd5;
            8'h2C: punct_kind = KIND_DELIM0 + 6'd6;
            8'h2E: punct_kind = KIND_DELIM0 + 6'd7;
            default: punct_kind = KIND_UNKNOWN;
        endcase
    end

    always_comb begin
        logic go_idle;
        go_idle    = 1'b0;
        mode_next  = mode_reg;
        line_next  = line_reg;
        start_next = start_reg;
        len_next   = len_reg;
        dots_next  = dots_reg;
        mask_next  = mask_reg;
        ra = '0;
        rb = '0;
        if (mode_reg == MODE_HALTED) begin
            ra.valid = 1'b1;
            ra.item  = mk(KIND_ERROR, start_reg, '0, line_reg);
        end else if (s_data.end_of_input) begin
            case (mode_reg)
                MODE_IDENT:  begin ra.valid = 1'b1;
                             ra.item = mk(ident_kind, start_reg, len_reg, line_reg); end
                MODE_NUMBER: begin ra.valid = 1'b1;
                             ra.item = mk(num_kind, start_reg, len_reg, line_reg); end
                MODE_STRING: begin ra.valid = 1'b1;
                             ra.item = mk(KIND_STRING, start_reg, len_reg, line_reg); end
                default: ;
            endcase
            rb.valid = 1'b1;
            if (mode_reg == MODE_BANG) begin
                rb.item   = mk(KIND_ERROR, start_reg, '0, line_reg);
                mode_next = MODE_HALTED;
            end else begin
                rb.item   = mk(KIND_END, pos_reg, '0, line_reg);
                mode_next = MODE_IDLE;
            end
        end else begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (id_cont) begin
                        mask_next = mask_upd;
                        len_next  = len_sat;
                    end else begin
                        ra.valid = 1'b1;
                        ra.item  = mk(ident_kind, start_reg, len_reg, line_reg);
                        go_idle  = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_dg || c == 8'h2E) begin
                        if (c == 8'h2E && dots_reg < 2'd2) dots_next = dots_reg + 2'd1;
                        len_next = len_sat;
                    end else begin
                        ra.valid = 1'b1;
                        ra.item  = mk(num_kind, start_reg, len_reg, line_reg);
                        go_idle  = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (is_pr && c != 8'h22) begin
                        len_next = len_sat;
                    end else begin
                        ra.valid  = 1'b1;
                        ra.item   = mk(KIND_STRING, start_reg, len_reg, line_reg);
                        mode_next = MODE_IDLE;
                        if (c == 8'h0A && line_reg != '1) line_next = line_reg + 32'd1;
                    end
                end
                MODE_BANG: begin
                    if (c == 8'h21) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        ra.valid  = 1'b1;
                        ra.item   = mk(KIND_ERROR, start_reg, '0, line_reg);
                        mode_next = MODE_HALTED;
                    end
                end
                MODE_COMMENT: begin
                    if (c == 8'h0A) begin
                        mode_next = MODE_IDLE;
                        if (line_reg != '1) line_next = line_reg + 32'd1;
                    end
                end
                default: go_idle = 1'b1;
            endcase
            if (go_idle) begin
                // handle the character as the first of a new scan
                mode_next = MODE_IDLE;
                if (c == 8'h0A) begin
                    if (line_reg != '1) line_next = line_reg + 32'd1;
                end else if (c == 8'h21) begin
                    mode_next  = MODE_BANG;
                    start_next = pos_reg;
                end else if (is_al) begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                    len_next   = LenW'(1);
                    mask_next  = mask_upd;
                end else if (is_dg) begin
                    mode_next  = MODE_NUMBER;
                    start_next = pos_reg;
                    len_next   = LenW'(1);
                    dots_next  = 2'd0;
                end else if (c == 8'h22) begin
                    mode_next  = MODE_STRING;
                    start_next = pos_reg + 32'd1;
                    len_next   = '0;
                end else if (is_pu) begin
                    rb.valid = 1'b1;
                    rb.item  = mk(punct_kind, pos_reg, LenW'(1), line_reg);
                end
            end
        end
        if (rb.valid) rb.item.last_of_run = 1'b1;
        else ra.item.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= 32'd1;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            dots_reg  <= '0;
            mask_reg  <= '1;
        end else if (acc) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            dots_reg  <= dots_next;
            mask_reg  <= mask_next;
            if (mode_reg != MODE_HALTED && !s_data.end_of_input) pos_reg <= pos_reg + 32'd1;
        end
    end

    ktl_out_queue u_q (
        .aclk(aclk), .aresetn(aresetn), .push(acc), .push_a(ra), .push_b(rb),
        .can_push(s_ready), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_data)
    );

    `include "keyword_token_lexer_unit_defines.svh"
    `KTL_ASSERT(a_halt_sticky, mode_reg == MODE_HALTED |=> mode_reg == MODE_HALTED,
                "left halted state")
    `KTL_ASSERT(a_line_nonzero, line_reg != 32'd0, "line counter zero")
    `KTL_ASSERT(a_halt_err, (acc && mode_reg == MODE_HALTED) |-> ra.valid && !rb.valid,
                "halted must answer one error")

endmodule
